// ----- hdl/pcaft_pkg.sv -----
package pcaft_pkg;

	// Field and register widths.
	localparam int KIND_WIDTH    = 2;
	localparam int DUR_WIDTH     = 20;
	localparam int RAW_WIDTH     = 16;
	localparam int MV_WIDTH      = 12;
	localparam int PULSE_WIDTH   = 16;
	localparam int OUT_CNT_WIDTH = 16;
	localparam int ARM_WIDTH     = 20;
	localparam int PERIOD_WIDTH  = 16;
	localparam int CFG_WIDTH     = 20;
	localparam int CFG_IDX_WIDTH = 3;

	// Default width of the completed-pulse counters.
	localparam int COUNT_WIDTH_DEF = 16;

	// Converter scaling: full scale code and full scale millivolts.
	localparam int MV_FULL_SCALE  = 3300;
	localparam int RAW_FULL_SCALE = 65535;
	localparam int PROD_WIDTH     = RAW_WIDTH + MV_WIDTH;

	// Item kinds.
	localparam logic [KIND_WIDTH-1:0] KIND_TICK   = 2'd0;
	localparam logic [KIND_WIDTH-1:0] KIND_ARM    = 2'd1;
	localparam logic [KIND_WIDTH-1:0] KIND_DISARM = 2'd2;
	localparam logic [KIND_WIDTH-1:0] KIND_FIRE   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ARM_TIMEOUT  = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_FIRE_DEFAULT = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_FIRE_MAX     = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESHOLD    = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_SENSE_PERIOD = 3'd4;

	// Configuration reset values.
	localparam logic [ARM_WIDTH-1:0]    ARM_TIMEOUT_RST  = 20'd30000;
	localparam logic [PULSE_WIDTH-1:0]  FIRE_DEFAULT_RST = 16'd1000;
	localparam logic [PULSE_WIDTH-1:0]  FIRE_MAX_RST     = 16'd2000;
	localparam logic [MV_WIDTH-1:0]     THRESHOLD_RST    = 12'd500;
	localparam logic [PERIOD_WIDTH-1:0] SENSE_PERIOD_RST = 16'd200;

	// One input beat.
	typedef struct packed {
		logic [KIND_WIDTH-1:0] kind;
		logic                  channel;
		logic [DUR_WIDTH-1:0]  duration_ticks;
		logic [RAW_WIDTH-1:0]  sense_raw_c;
		logic [RAW_WIDTH-1:0]  sense_raw_d;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic                     drive_c;
		logic                     drive_d;
		logic                     is_armed;
		logic                     fire_accepted;
		logic                     continuity_c;
		logic                     continuity_d;
		logic [MV_WIDTH-1:0]      sense_mv_c;
		logic [MV_WIDTH-1:0]      sense_mv_d;
		logic [OUT_CNT_WIDTH-1:0] count_c;
		logic [OUT_CNT_WIDTH-1:0] count_d;
		logic                     sense_taken;
	} result_t;

	// Command from the controller to one channel lane.
	typedef struct packed {
		logic                   tick;
		logic                   fire;
		logic                   drop;
		logic                   sample;
		logic [PULSE_WIDTH-1:0] dur;
		logic [MV_WIDTH-1:0]    mv;
	} lane_cmd_t;

	// Status from one channel lane back to the merge stage.
	typedef struct packed {
		logic                busy;
		logic                active_nxt;
		logic [MV_WIDTH-1:0] mv_nxt;
	} lane_stat_t;

endpackage

// ----- hdl/pcaft_mv.sv -----
module pcaft_mv (
	input  logic                             clk,
	input  logic                             en,
	input  logic [pcaft_pkg::RAW_WIDTH-1:0]  raw,
	output logic [pcaft_pkg::MV_WIDTH-1:0]   mv_s1
);
	import pcaft_pkg::*;

	logic [PROD_WIDTH-1:0]  prod;
	logic [MV_WIDTH-1:0]    quo;
	logic [RAW_WIDTH:0]     rem;
	logic [MV_WIDTH-1:0]    mv;

	// Scale to millivolts. Dividing by 2^16 - 1 is a shift plus one correction:
	// x = q*65535 + (low16 + q), and that remainder stays below twice the divisor.
	always_comb begin
		prod = PROD_WIDTH'(raw) * PROD_WIDTH'(MV_FULL_SCALE);
		quo  = prod[PROD_WIDTH-1:RAW_WIDTH];
		rem  = {1'b0, prod[RAW_WIDTH-1:0]} + (RAW_WIDTH+1)'(quo);
		if (rem >= (RAW_WIDTH+1)'(RAW_FULL_SCALE)) begin
			mv = quo + MV_WIDTH'(1);
		end else begin
			mv = quo;
		end
	end

	// Stage one register for the converted reading.
	always_ff @(posedge clk) begin
		if (en) begin
			mv_s1 <= mv;
		end
	end

endmodule

// ----- hdl/pcaft_lane.sv -----
module pcaft_lane #(
	parameter int COUNT_WIDTH = pcaft_pkg::COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  pcaft_pkg::lane_cmd_t   cmd,
	output pcaft_pkg::lane_stat_t  stat,
	output logic [COUNT_WIDTH-1:0] count_nxt
);
	import pcaft_pkg::*;

	logic                   active_q;
	logic [PULSE_WIDTH-1:0] rem_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [MV_WIDTH-1:0]    mv_q;

	logic                   active_d;
	logic [PULSE_WIDTH-1:0] rem_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic [MV_WIDTH-1:0]    mv_d;

	// Next state of this channel: pulse end and count, new pulse, forced drop,
	// then a fresh reading when the channel is idle after all of that.
	always_comb begin
		active_d = active_q;
		rem_d    = rem_q;
		count_d  = count_q;
		mv_d     = mv_q;
		if (cmd.tick && active_d) begin
			if (rem_d <= PULSE_WIDTH'(1)) begin
				active_d = 1'b0;
				rem_d    = '0;
				count_d  = count_d + COUNT_WIDTH'(1);
			end else begin
				rem_d = rem_d - PULSE_WIDTH'(1);
			end
		end
		if (cmd.fire) begin
			active_d = 1'b1;
			rem_d    = cmd.dur;
		end
		if (cmd.drop) begin
			active_d = 1'b0;
			rem_d    = '0;
		end
		if (cmd.sample && !active_d) begin
			mv_d = cmd.mv;
		end
	end

	// Channel state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rem_q    <= '0;
			count_q  <= '0;
			mv_q     <= '0;
		end else if (go) begin
			active_q <= active_d;
			rem_q    <= rem_d;
			count_q  <= count_d;
			mv_q     <= mv_d;
		end
	end

	assign stat.busy       = active_q;
	assign stat.active_nxt = active_d;
	assign stat.mv_nxt     = mv_d;
	assign count_nxt       = count_d;

endmodule

// ----- hdl/pyro_channel_arm_fire_timer_top.sv -----
// Two-channel igniter controller. Each beat on the item channel is a tick, an
// arm, a disarm or a fire command, and yields exactly one result beat that
// shows the state after that item. The block takes one item per clock cycle
// when the result side does not stall. Both sense samples are converted to
// millivolts as the item is taken into stage one, with one multiplier per
// channel. When the result register can take a beat, stage one applies the
// item to the channel lanes and the arm and sense timers, and loads the
// result register. A stalled result holds stage one, so with both stages
// full the item side stalls. Configuration is written through cfg_we,
// cfg_index and cfg_wdata and must only change while no item is in flight and
// no result is waiting.
module pyro_channel_arm_fire_timer_top #(
	parameter int COUNT_WIDTH = pcaft_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  pcaft_pkg::item_t                     item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output pcaft_pkg::result_t                   result,
	input  logic                                 cfg_we,
	input  logic [pcaft_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [pcaft_pkg::CFG_WIDTH-1:0]      cfg_wdata
);
	import pcaft_pkg::*;

	// Configuration registers.
	logic [ARM_WIDTH-1:0]    arm_timeout_q;
	logic [PULSE_WIDTH-1:0]  fire_default_q;
	logic [PULSE_WIDTH-1:0]  fire_max_q;
	logic [MV_WIDTH-1:0]     threshold_q;
	logic [PERIOD_WIDTH-1:0] sense_period_q;

	// Pipeline control.
	logic    s1_valid;
	item_t   item_s1;
	logic    out_en;
	logic    s1_en;
	logic    go;
	logic [MV_WIDTH-1:0] mv_c_s1;
	logic [MV_WIDTH-1:0] mv_d_s1;

	// Shared controller state.
	logic                    armed_q;
	logic [ARM_WIDTH-1:0]    arm_rem_q;
	logic [PERIOD_WIDTH-1:0] sense_wait_q;

	// Decoded item and controller decisions.
	logic                    is_tick;
	logic                    is_arm;
	logic                    is_disarm;
	logic                    is_fire;
	logic                    ch_busy;
	logic                    accepted;
	logic                    expire;
	logic                    sample;
	logic                    drop;
	logic [DUR_WIDTH-1:0]    dur_req;
	logic [PULSE_WIDTH-1:0]  dur_sat;
	logic                    armed_d;
	logic [ARM_WIDTH-1:0]    arm_rem_d;
	logic [PERIOD_WIDTH-1:0] sense_wait_d;

	lane_cmd_t               cmd_c;
	lane_cmd_t               cmd_d;
	lane_stat_t              stat_c;
	lane_stat_t              stat_d;
	logic [COUNT_WIDTH-1:0]  count_c_nxt;
	logic [COUNT_WIDTH-1:0]  count_d_nxt;
	result_t                 result_d;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_timeout_q  <= ARM_TIMEOUT_RST;
			fire_default_q <= FIRE_DEFAULT_RST;
			fire_max_q     <= FIRE_MAX_RST;
			threshold_q    <= THRESHOLD_RST;
			sense_period_q <= SENSE_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ARM_TIMEOUT:  arm_timeout_q  <= cfg_wdata[ARM_WIDTH-1:0];
				CFG_FIRE_DEFAULT: fire_default_q <= cfg_wdata[PULSE_WIDTH-1:0];
				CFG_FIRE_MAX:     fire_max_q     <= cfg_wdata[PULSE_WIDTH-1:0];
				CFG_THRESHOLD:    threshold_q    <= cfg_wdata[MV_WIDTH-1:0];
				CFG_SENSE_PERIOD: sense_period_q <= cfg_wdata[PERIOD_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the result register frees up when empty or taken, and stage one
	// moves whenever the result register can take its beat.
	assign out_en     = !result_valid || !result_stall;
	assign go         = s1_valid && out_en;
	assign s1_en      = !s1_valid || out_en;
	assign item_stall = !s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_valid <= item_valid;
			end
			if (out_en) begin
				result_valid <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && item_valid) begin
			item_s1 <= item;
		end
	end

	// Millivolt conversion, one unit per channel.
	pcaft_mv u_mv_c (
		.clk   (clk),
		.en    (s1_en && item_valid),
		.raw   (item.sense_raw_c),
		.mv_s1 (mv_c_s1)
	);

	pcaft_mv u_mv_d (
		.clk   (clk),
		.en    (s1_en && item_valid),
		.raw   (item.sense_raw_d),
		.mv_s1 (mv_d_s1)
	);

	// Item decode and fire duration: zero picks the default, then clamp to max.
	always_comb begin
		is_tick   = item_s1.kind == KIND_TICK;
		is_arm    = item_s1.kind == KIND_ARM;
		is_disarm = item_s1.kind == KIND_DISARM;
		is_fire   = item_s1.kind == KIND_FIRE;
		ch_busy   = item_s1.channel ? stat_d.busy : stat_c.busy;
		accepted  = is_fire && armed_q && !ch_busy;
		expire    = is_tick && armed_q && (arm_rem_q <= ARM_WIDTH'(1));
		sample    = is_tick && (sense_wait_q == '0);
		drop      = is_disarm || expire;
		if (item_s1.duration_ticks == '0) begin
			dur_req = DUR_WIDTH'(fire_default_q);
		end else begin
			dur_req = item_s1.duration_ticks;
		end
		if (dur_req > DUR_WIDTH'(fire_max_q)) begin
			dur_sat = fire_max_q;
		end else begin
			dur_sat = dur_req[PULSE_WIDTH-1:0];
		end
	end

	// Arm countdown and sense period timer.
	always_comb begin
		armed_d      = armed_q;
		arm_rem_d    = arm_rem_q;
		sense_wait_d = sense_wait_q;
		if (is_arm) begin
			armed_d   = 1'b1;
			arm_rem_d = arm_timeout_q;
		end else if (is_disarm || expire) begin
			armed_d   = 1'b0;
			arm_rem_d = '0;
		end else if (is_tick && armed_q) begin
			arm_rem_d = arm_rem_q - ARM_WIDTH'(1);
		end
		if (is_tick) begin
			if (sense_wait_q == '0) begin
				if (sense_period_q == '0) begin
					sense_wait_d = '0;
				end else begin
					sense_wait_d = sense_period_q - PERIOD_WIDTH'(1);
				end
			end else begin
				sense_wait_d = sense_wait_q - PERIOD_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			arm_rem_q    <= '0;
			sense_wait_q <= '0;
		end else if (go) begin
			armed_q      <= armed_d;
			arm_rem_q    <= arm_rem_d;
			sense_wait_q <= sense_wait_d;
		end
	end

	// Commands to the two channel lanes.
	always_comb begin
		cmd_c.tick   = is_tick;
		cmd_c.fire   = accepted && !item_s1.channel;
		cmd_c.drop   = drop;
		cmd_c.sample = sample;
		cmd_c.dur    = dur_sat;
		cmd_c.mv     = mv_c_s1;
		cmd_d.tick   = is_tick;
		cmd_d.fire   = accepted && item_s1.channel;
		cmd_d.drop   = drop;
		cmd_d.sample = sample;
		cmd_d.dur    = dur_sat;
		cmd_d.mv     = mv_d_s1;
	end

	pcaft_lane #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_lane_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.cmd       (cmd_c),
		.stat      (stat_c),
		.count_nxt (count_c_nxt)
	);

	pcaft_lane #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_lane_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.cmd       (cmd_d),
		.stat      (stat_d),
		.count_nxt (count_d_nxt)
	);

	// Merge the lanes and the controller into one result beat.
	always_comb begin
		result_d.drive_c       = stat_c.active_nxt;
		result_d.drive_d       = stat_d.active_nxt;
		result_d.is_armed      = armed_d;
		result_d.fire_accepted = accepted;
		result_d.continuity_c  = stat_c.mv_nxt > threshold_q;
		result_d.continuity_d  = stat_d.mv_nxt > threshold_q;
		result_d.sense_mv_c    = stat_c.mv_nxt;
		result_d.sense_mv_d    = stat_d.mv_nxt;
		result_d.count_c       = OUT_CNT_WIDTH'(count_c_nxt);
		result_d.count_d       = OUT_CNT_WIDTH'(count_d_nxt);
		result_d.sense_taken   = sample;
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result <= result_d;
		end
	end

endmodule

// ----- tb/sv/pcaft_result_checker.sv -----
`timescale 1ns / 1ps

module pcaft_result_checker #(
	parameter int COUNT_WIDTH = pcaft_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  logic                                item_stall,
	input  pcaft_pkg::item_t                    item,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  pcaft_pkg::result_t                  result,
	input  logic                                cfg_we,
	input  logic [pcaft_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [pcaft_pkg::CFG_WIDTH-1:0]     cfg_wdata,
	output int                                  mismatches,
	output int                                  outstanding
);

	import pcaft_pkg::*;

	localparam int MAX_REPORTS = 10;

	// Shadow copy of the configuration registers.
	logic [ARM_WIDTH-1:0]    arm_timeout;
	logic [PULSE_WIDTH-1:0]  fire_default;
	logic [PULSE_WIDTH-1:0]  fire_max;
	logic [MV_WIDTH-1:0]     threshold;
	logic [PERIOD_WIDTH-1:0] sense_period;

	// Predicted controller state.
	logic                    armed;
	logic [ARM_WIDTH-1:0]    arm_left;
	logic [1:0]              firing;
	logic [PULSE_WIDTH-1:0]  pulse_left [2];
	logic [COUNT_WIDTH-1:0]  pulses_done [2];
	logic [MV_WIDTH-1:0]     held_mv [2];
	logic [PERIOD_WIDTH-1:0] sense_wait;

	// Results predicted for accepted items, oldest first.
	result_t expected_results [$];
	int      results_seen;

	// Converter code to millivolts, truncated.
	function automatic logic [MV_WIDTH-1:0] raw_to_millivolts(input logic [RAW_WIDTH-1:0] raw);
		int unsigned scaled;
		scaled = 32'(raw);
		scaled = scaled * MV_FULL_SCALE / RAW_FULL_SCALE;
		return scaled[MV_WIDTH-1:0];
	endfunction

	// Both igniter outputs off, without counting a completed pulse.
	task automatic cut_drives();
		firing = 2'b00;
		pulse_left[0] = '0;
		pulse_left[1] = '0;
	endtask

	// Applies one item to the predicted state and forms the result it causes.
	task automatic step_controller(input item_t it, output result_t r);
		logic [DUR_WIDTH-1:0] len;
		logic                 started;
		logic                 sampled;
		started = 1'b0;
		sampled = 1'b0;
		case (it.kind)
		KIND_ARM: begin
			armed = 1'b1;
			arm_left = arm_timeout;
		end
		KIND_DISARM: begin
			armed = 1'b0;
			arm_left = '0;
			cut_drives();
		end
		KIND_FIRE: begin
			if (armed && !firing[it.channel]) begin
				len = it.duration_ticks;
				if (len == '0)
					len = DUR_WIDTH'(fire_default);
				if (len > DUR_WIDTH'(fire_max))
					len = DUR_WIDTH'(fire_max);
				pulse_left[it.channel] = len[PULSE_WIDTH-1:0];
				firing[it.channel] = 1'b1;
				started = 1'b1;
			end
		end
		default: begin
			// Pulses end first, then the arm countdown, then the sense refresh.
			for (int c = 0; c < 2; c++) begin
				if (firing[c]) begin
					if (pulse_left[c] <= 1) begin
						firing[c] = 1'b0;
						pulse_left[c] = '0;
						pulses_done[c] = pulses_done[c] + COUNT_WIDTH'(1);
					end else begin
						pulse_left[c] = pulse_left[c] - PULSE_WIDTH'(1);
					end
				end
			end
			if (armed) begin
				if (arm_left <= 1) begin
					armed = 1'b0;
					arm_left = '0;
					cut_drives();
				end else begin
					arm_left = arm_left - ARM_WIDTH'(1);
				end
			end
			if (sense_wait == '0) begin
				sampled = 1'b1;
				sense_wait = (sense_period == '0) ? '0 : sense_period - PERIOD_WIDTH'(1);
				if (!firing[0])
					held_mv[0] = raw_to_millivolts(it.sense_raw_c);
				if (!firing[1])
					held_mv[1] = raw_to_millivolts(it.sense_raw_d);
			end else begin
				sense_wait = sense_wait - PERIOD_WIDTH'(1);
			end
		end
		endcase

		r.drive_c       = firing[0];
		r.drive_d       = firing[1];
		r.is_armed      = armed;
		r.fire_accepted = started;
		r.continuity_c  = held_mv[0] > threshold;
		r.continuity_d  = held_mv[1] > threshold;
		r.sense_mv_c    = held_mv[0];
		r.sense_mv_d    = held_mv[1];
		r.count_c       = OUT_CNT_WIDTH'(pulses_done[0]);
		r.count_d       = OUT_CNT_WIDTH'(pulses_done[1]);
		r.sense_taken   = sampled;
	endtask

	function automatic string field_diff(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v)
			return $sformatf(" %s exp %0d got %0d", name, want_v, got_v);
		return "";
	endfunction

	// Compares one result beat with the oldest prediction.
	task automatic check_result(input result_t got);
		result_t want;
		string   diffs;
		results_seen++;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("result %0d arrived with nothing outstanding: %h", results_seen, got);
			return;
		end
		want = expected_results.pop_front();
		diffs = {field_diff("drive_c", 16'(want.drive_c), 16'(got.drive_c)),
			field_diff("drive_d", 16'(want.drive_d), 16'(got.drive_d)),
			field_diff("is_armed", 16'(want.is_armed), 16'(got.is_armed)),
			field_diff("fire_accepted", 16'(want.fire_accepted), 16'(got.fire_accepted)),
			field_diff("continuity_c", 16'(want.continuity_c), 16'(got.continuity_c)),
			field_diff("continuity_d", 16'(want.continuity_d), 16'(got.continuity_d)),
			field_diff("sense_mv_c", 16'(want.sense_mv_c), 16'(got.sense_mv_c)),
			field_diff("sense_mv_d", 16'(want.sense_mv_d), 16'(got.sense_mv_d)),
			field_diff("count_c", want.count_c, got.count_c),
			field_diff("count_d", want.count_d, got.count_d),
			field_diff("sense_taken", 16'(want.sense_taken), 16'(got.sense_taken))};
		if (diffs != "") begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("result %0d mismatch:%s", results_seen, diffs);
		end
	endtask

	// Track register writes, check result beats, predict for accepted item beats.
	always @(posedge clk or negedge arst_n) begin
		result_t predicted;
		if (!arst_n) begin
			arm_timeout = ARM_TIMEOUT_RST;
			fire_default = FIRE_DEFAULT_RST;
			fire_max = FIRE_MAX_RST;
			threshold = THRESHOLD_RST;
			sense_period = SENSE_PERIOD_RST;
			armed = 1'b0;
			arm_left = '0;
			cut_drives();
			pulses_done[0] = '0;
			pulses_done[1] = '0;
			held_mv[0] = '0;
			held_mv[1] = '0;
			sense_wait = '0;
			expected_results.delete();
			results_seen = 0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_ARM_TIMEOUT:  arm_timeout = cfg_wdata[ARM_WIDTH-1:0];
				CFG_FIRE_DEFAULT: fire_default = cfg_wdata[PULSE_WIDTH-1:0];
				CFG_FIRE_MAX:     fire_max = cfg_wdata[PULSE_WIDTH-1:0];
				CFG_THRESHOLD:    threshold = cfg_wdata[MV_WIDTH-1:0];
				CFG_SENSE_PERIOD: sense_period = cfg_wdata[PERIOD_WIDTH-1:0];
				default: ;
				endcase
			end
			if (result_valid && !result_stall)
				check_result(result);
			if (item_valid && !item_stall) begin
				step_controller(item, predicted);
				expected_results.push_back(predicted);
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ----- tb/sv/tb_pyro_channel_arm_fire_timer_top.sv -----
`timescale 1ns / 1ps

module tb_pyro_channel_arm_fire_timer_top;

	import pcaft_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 150;
	localparam int RAND_PHASES   = 6;
	localparam int PHASE_ITEMS   = 205;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [ARM_WIDTH-1:0]    arm_timeout;
		logic [PULSE_WIDTH-1:0]  fire_default;
		logic [PULSE_WIDTH-1:0]  fire_max;
		logic [MV_WIDTH-1:0]     threshold;
		logic [PERIOD_WIDTH-1:0] sense_period;
	} settings_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     item_valid;
	logic                     item_stall;
	item_t                    item;
	logic                     result_valid;
	logic                     result_stall;
	result_t                  result;
	logic                     cfg_we;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0]     cfg_wdata;
	int                       mismatches;
	int                       outstanding;

	settings_t cur;
	bit        hold_req;
	bit        quiet;
	int        burst_left;
	int        cycles;

	pyro_channel_arm_fire_timer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	pcaft_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Free-running clock.
	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Idle length: mostly none, some short, a few long.
	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side back-pressure, with a long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0)
				stall_left--;
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = idle_len();
			end
			result_stall <= (stall_left > 0);
		end
	end

	// Offers one beat after a random gap and returns at the edge that takes it.
	task automatic send_beat(input item_t b);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = idle_len();
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= b;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	// Stops offering and waits until every predicted result has come back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Writes all five registers back to back; only called while drained.
	task automatic load_settings(input settings_t s);
		cur = s;
		cfg_we <= 1'b1;
		cfg_index <= CFG_ARM_TIMEOUT;
		cfg_wdata <= s.arm_timeout;
		@(posedge clk);
		cfg_index <= CFG_FIRE_DEFAULT;
		cfg_wdata <= CFG_WIDTH'(s.fire_default);
		@(posedge clk);
		cfg_index <= CFG_FIRE_MAX;
		cfg_wdata <= CFG_WIDTH'(s.fire_max);
		@(posedge clk);
		cfg_index <= CFG_THRESHOLD;
		cfg_wdata <= CFG_WIDTH'(s.threshold);
		@(posedge clk);
		cfg_index <= CFG_SENSE_PERIOD;
		cfg_wdata <= CFG_WIDTH'(s.sense_period);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t make_beat(input logic [KIND_WIDTH-1:0] kind, input logic ch,
			input logic [DUR_WIDTH-1:0] dur, input logic [RAW_WIDTH-1:0] raw_c,
			input logic [RAW_WIDTH-1:0] raw_d);
		item_t b;
		b.kind = kind;
		b.channel = ch;
		b.duration_ticks = dur;
		b.sense_raw_c = raw_c;
		b.sense_raw_d = raw_d;
		return b;
	endfunction

	// Sense sample: rails, values around the current threshold, or anything.
	function automatic logic [RAW_WIDTH-1:0] random_raw();
		int r;
		int code;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		if (r < 35) begin
			code = int'(cur.threshold) * RAW_FULL_SCALE / MV_FULL_SCALE;
			code = code + $urandom_range(0, 40) - 20;
			if (code < 0)
				code = 0;
			if (code > RAW_FULL_SCALE)
				code = RAW_FULL_SCALE;
			return RAW_WIDTH'(code);
		end
		return RAW_WIDTH'($urandom_range(0, RAW_FULL_SCALE));
	endfunction

	// Random command, weighted so that arming and firing keep happening.
	function automatic item_t random_command();
		item_t b;
		int    r;
		r = $urandom_range(0, 99);
		if (r < 60)
			b.kind = KIND_TICK;
		else if (r < 71)
			b.kind = KIND_ARM;
		else if (r < 75)
			b.kind = KIND_DISARM;
		else
			b.kind = KIND_FIRE;
		b.channel = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 20)
			b.duration_ticks = '0;
		else if (r < 75)
			b.duration_ticks = DUR_WIDTH'($urandom_range(1, int'(cur.fire_max) + 3));
		else if (r < 90)
			b.duration_ticks = DUR_WIDTH'($urandom_range(0, 65535));
		else
			b.duration_ticks = DUR_WIDTH'($urandom_range(0, 20'hFFFFF));
		b.sense_raw_c = random_raw();
		b.sense_raw_d = random_raw();
		return b;
	endfunction

	// Mostly short timers so that pulses end and arming expires often.
	function automatic settings_t random_settings();
		settings_t s;
		int        r;
		r = $urandom_range(0, 99);
		if (r < 70)
			s.arm_timeout = ARM_WIDTH'($urandom_range(1, 80));
		else if (r < 92)
			s.arm_timeout = ARM_WIDTH'($urandom_range(81, 5000));
		else
			s.arm_timeout = ARM_WIDTH'($urandom_range(1, 20'hFFFFF));
		s.fire_default = PULSE_WIDTH'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 30)
			: $urandom_range(1, 65535));
		s.fire_max = PULSE_WIDTH'(($urandom_range(0, 99) < 80) ? $urandom_range(1, 40)
			: $urandom_range(1, 65535));
		s.threshold = MV_WIDTH'($urandom_range(0, MV_FULL_SCALE));
		s.sense_period = PERIOD_WIDTH'(($urandom_range(0, 99) < 75) ? $urandom_range(1, 8)
			: $urandom_range(1, 400));
		return s;
	endfunction

	// Stimulus and verdict.
	initial begin
		int ph;
		int n;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		hold_req = 1'b0;
		quiet = 1'b0;
		burst_left = 0;
		cycles = 0;
		cur = '{ARM_TIMEOUT_RST, FIRE_DEFAULT_RST, FIRE_MAX_RST, THRESHOLD_RST,
			SENSE_PERIOD_RST};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: first tick samples, refused fires, saturation, disarm.
		send_beat(make_beat(KIND_TICK, 1'b0, '0, 16'h0000, 16'hFFFF));
		send_beat(make_beat(KIND_FIRE, 1'b0, 20'd5, '0, '0));
		send_beat(make_beat(KIND_DISARM, 1'b0, '0, '0, '0));
		send_beat(make_beat(KIND_ARM, 1'b0, '0, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b0, 20'd0, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b0, 20'd3, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b1, 20'hFFFFF, '0, '0));
		send_beat(make_beat(KIND_ARM, 1'b1, '0, '0, '0));
		send_beat(make_beat(KIND_TICK, 1'b1, '0, 16'hFFFF, 16'h0000));
		send_beat(make_beat(KIND_DISARM, 1'b1, '0, '0, '0));

		// Short timers, default above maximum, sampling on every tick,
		// readings on either side of the threshold, and arm expiry mid-pulse.
		wait_drained();
		load_settings('{20'd3, 16'hFFFF, 16'd4, 12'd500, 16'd1});
		send_beat(make_beat(KIND_TICK, 1'b0, '0, 16'd9930, 16'd9950));
		send_beat(make_beat(KIND_ARM, 1'b0, '0, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b0, 20'd0, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b1, 20'd1, '0, '0));
		send_beat(make_beat(KIND_TICK, 1'b0, '0, 16'hFFFF, 16'hFFFF));
		send_beat(make_beat(KIND_TICK, 1'b0, '0, 16'd0, 16'd0));
		send_beat(make_beat(KIND_TICK, 1'b0, '0, 16'h5555, 16'hAAAA));

		// Zero countdowns and zero sense period: everything ends on the next tick.
		wait_drained();
		load_settings('{20'd0, 16'd0, 16'd0, 12'd0, 16'd0});
		send_beat(make_beat(KIND_ARM, 1'b0, '0, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b0, 20'd7, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b1, 20'd0, '0, '0));
		send_beat(make_beat(KIND_TICK, 1'b0, '0, 16'd1, 16'd20));
		send_beat(make_beat(KIND_TICK, 1'b0, '0, 16'hFFFF, 16'hFFFF));

		// Largest settings: full-scale reading sits exactly at the threshold.
		wait_drained();
		load_settings('{20'hFFFFF, 16'hFFFF, 16'hFFFF, 12'd3300, 16'hFFFF});
		send_beat(make_beat(KIND_TICK, 1'b0, '0, 16'hFFFF, 16'hFFFE));
		send_beat(make_beat(KIND_ARM, 1'b0, '0, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b0, 20'd0, '0, '0));
		send_beat(make_beat(KIND_FIRE, 1'b1, 20'h1FFFF, '0, '0));
		send_beat(make_beat(KIND_TICK, 1'b0, '0, '0, '0));

		// Random phases, each under fresh settings.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			if (ph == 4)
				load_settings('{20'hFFFFF, 16'hFFFF, 16'hFFFF,
					12'($urandom_range(0, MV_FULL_SCALE)), 16'hFFFF});
			else if (ph == 5)
				load_settings('{20'd1, 16'd1, 16'd1, 12'd0, 16'd1});
			else
				load_settings(random_settings());
			quiet = (ph == 1);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Receiver holds off while items keep coming back to back.
				if (ph == 2 && n == 40) begin
					hold_req = 1'b1;
					burst_left = 60;
				end
				// Sender pauses until everything has come back.
				if (ph == 3 && n == 100)
					wait_drained();
				send_beat(random_command());
			end
		end
		quiet = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
